### hw/rtl/hkrt_pkg.sv
// ----------------------------------------------------------------------------
// hkrt_pkg
// shared types and constants for the held key release timeout tracker
// ----------------------------------------------------------------------------
package hkrt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_MODS,
    ST_PRESS,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    REG_FIRST_DELAY  = 2'd0,
    REG_NEXT_DELAY   = 2'd1,
    REG_MAX_RAW_CODE = 2'd2
  } reg_idx_t;

  localparam logic KIND_TICK = 1'b0;
  localparam logic SRC_KEY   = 1'b0;
  localparam logic SRC_MOD   = 1'b1;

  localparam logic [7:0] FIRST_DELAY_RST  = 8'd25;
  localparam logic [7:0] NEXT_DELAY_RST   = 8'd5;
  localparam logic [7:0] MAX_RAW_CODE_RST = 8'd99;

  localparam logic [2:0] RCTRL_BIT    = 3'd4;
  localparam logic [2:0] MOD_BIT_LAST = 3'd7;
  localparam logic [3:0] MAX_RESULTS  = 4'd8;

  typedef struct packed {
    logic       src;
    logic [6:0] code;
    logic       pressed;
  } event_t;

  typedef struct packed {
    logic load;
    logic step_tick;
    logic step_mod;
    logic do_press;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic in_kind;
    logic in_raw_ok;
    logic key_nz;
    logic slot_last;
    logic bit_last;
    logic tick_emit;
    logic mod_emit;
    logic press_emit;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

### hw/rtl/hkrt_dp.sv
// ----------------------------------------------------------------------------
// hkrt_dp
// slot table, modifier state, config registers and the event staging path
// ----------------------------------------------------------------------------
module hkrt_dp import hkrt_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output status_t    st,
  input  logic       in_kind,
  input  logic [7:0] in_raw_code,
  input  logic [6:0] in_key_code,
  input  logic [7:0] in_modifiers,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_event_source,
  output logic [6:0] out_event_code,
  output logic       out_pressed,
  output logic       out_last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = (IDX_W > 3) ? IDX_W : 3;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       n_r, n_nxt;
  logic [6:0]       key_r;
  logic [7:0]       mods_r;
  logic [7:0]       mod_state_r;
  logic [7:0]       first_delay_r, next_delay_r, max_raw_code_r;
  logic [SLOTS-1:0] used_r;
  logic [6:0]       slot_key_r [SLOTS];
  logic [7:0]       slot_cnt_r [SLOTS];
  event_t           pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;
  event_t           out_r, out_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_v_r, out_v_nxt;

  logic [IDX_W-1:0] idx;
  logic [2:0]       bidx;
  logic             cur_used;
  logic [6:0]       cur_key;
  logic [7:0]       cur_cnt;
  logic [7:0]       diff;
  logic             hit_found, free_found;
  logic [IDX_W-1:0] hit_idx, free_idx;
  logic             emit_en;
  event_t           ev;

  assign idx      = cnt_r[IDX_W-1:0];
  assign bidx     = cnt_r[2:0];
  assign cur_used = used_r[idx];
  assign cur_key  = slot_key_r[idx];
  assign cur_cnt  = slot_cnt_r[idx];
  assign diff     = mods_r ^ mod_state_r;

  // first held slot with this key, first free slot
  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!hit_found && used_r[i] && (slot_key_r[i] == key_r)) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
      if (!free_found && !used_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    st.in_kind    = in_kind;
    st.in_raw_ok  = (in_raw_code <= max_raw_code_r);
    st.key_nz     = (key_r != 7'd0);
    st.slot_last  = (cnt_r == CNT_W'(SLOTS - 1));
    st.bit_last   = (cnt_r == CNT_W'(MOD_BIT_LAST));
    st.tick_emit  = cur_used && (cur_cnt == 8'd0) && (n_r < MAX_RESULTS);
    st.mod_emit   = diff[bidx] && (bidx != RCTRL_BIT);
    st.press_emit = hit_found || free_found;
    st.pend_valid = pend_v_r;
    st.out_free   = !out_v_r || !out_stall;
  end

  always_comb begin
    emit_en = 1'b0;
    ev      = '0;
    if (cmd.step_tick && st.tick_emit) begin
      emit_en    = 1'b1;
      ev.src     = SRC_KEY;
      ev.code    = cur_key;
      ev.pressed = 1'b0;
    end
    if (cmd.step_mod && st.mod_emit) begin
      emit_en    = 1'b1;
      ev.src     = SRC_MOD;
      ev.code    = {4'd0, bidx};
      ev.pressed = mods_r[bidx];
    end
    if (cmd.do_press && st.press_emit) begin
      emit_en    = 1'b1;
      ev.src     = SRC_KEY;
      ev.code    = key_r;
      ev.pressed = 1'b1;
    end
  end

  // one word staged so the final word of an item can carry last
  always_comb begin
    cnt_nxt      = cnt_r;
    n_nxt        = n_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    out_v_nxt    = out_v_r && out_stall;
    if (cmd.load) begin
      cnt_nxt = '0;
      n_nxt   = 4'd0;
    end else if (cmd.step_tick || cmd.step_mod) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (emit_en) begin
      n_nxt      = n_r + 4'd1;
      pend_nxt   = ev;
      pend_v_nxt = 1'b1;
      if (pend_v_r) begin
        out_nxt      = pend_r;
        out_last_nxt = 1'b0;
        out_v_nxt    = 1'b1;
      end
    end
    if (cmd.flush) begin
      out_nxt      = pend_r;
      out_last_nxt = 1'b1;
      out_v_nxt    = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r       <= 1'b0;
      out_v_r        <= 1'b0;
      mod_state_r    <= 8'd0;
      first_delay_r  <= FIRST_DELAY_RST;
      next_delay_r   <= NEXT_DELAY_RST;
      max_raw_code_r <= MAX_RAW_CODE_RST;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      if (cmd.step_mod && st.bit_last) begin
        mod_state_r <= mods_r;
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_FIRST_DELAY:  first_delay_r  <= cfg_data;
          REG_NEXT_DELAY:   next_delay_r   <= cfg_data;
          REG_MAX_RAW_CODE: max_raw_code_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    n_r        <= n_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    if (cmd.load) begin
      key_r  <= in_key_code;
      mods_r <= in_modifiers;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      if (cmd.step_tick && st.tick_emit) begin
        used_r[idx] <= 1'b0;
      end
      if (cmd.do_press && !hit_found && free_found) begin
        used_r[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_tick && cur_used && (cur_cnt != 8'd0)) begin
      slot_cnt_r[idx] <= cur_cnt - 8'd1;
    end
    if (cmd.do_press) begin
      if (hit_found) begin
        slot_cnt_r[hit_idx] <= next_delay_r;
      end else if (free_found) begin
        slot_cnt_r[free_idx] <= first_delay_r;
        slot_key_r[free_idx] <= key_r;
      end
    end
  end

  assign out_valid        = out_v_r;
  assign out_event_source = out_r.src;
  assign out_event_code   = out_r.code;
  assign out_pressed      = out_r.pressed;
  assign out_last         = out_last_r;

endmodule

### hw/rtl/hkrt_ctrl.sv
// ----------------------------------------------------------------------------
// hkrt_ctrl
// sequencer that walks the slots or modifier bits and closes each item
// ----------------------------------------------------------------------------
module hkrt_ctrl import hkrt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   held_off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    held_off  = st.pend_valid && !st.out_free;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (st.in_kind == KIND_TICK) begin
            state_nxt = ST_TICK;
          end else if (st.in_raw_ok) begin
            state_nxt = ST_MODS;
          end
        end
      end
      ST_TICK: begin
        if (!(st.tick_emit && held_off)) begin
          cmd.step_tick = 1'b1;
          if (st.slot_last) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_MODS: begin
        if (!(st.mod_emit && held_off)) begin
          cmd.step_mod = 1'b1;
          if (st.bit_last) begin
            state_nxt = st.key_nz ? ST_PRESS : ST_FLUSH;
          end
        end
      end
      ST_PRESS: begin
        if (!(st.press_emit && held_off)) begin
          cmd.do_press = 1'b1;
          state_nxt    = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!st.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (st.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/held_key_release_timeout_tracker_top.sv
// ----------------------------------------------------------------------------
// held_key_release_timeout_tracker_top
// turns auto-repeated key reports into press and release events
// ----------------------------------------------------------------------------
// Items are taken one at a time; in_stall stays high until every event of the
// current item has been handed to the output register. A frame tick is handled
// as the accept, a countdown step for each slot of the table, and the release of
// the final word. A key report is handled as the accept, a step for each modifier
// bit, the slot lookup and update (skipped when the key code is 0), and the
// release of the final word. A report whose raw code is above max_raw_code is
// accepted and gives no events. A full output register that meets a stall on the
// result side holds the current step. Config writes are always taken (cfg_ready
// is high).
module held_key_release_timeout_tracker_top import hkrt_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_raw_code,
  input  logic [6:0] in_key_code,
  input  logic [7:0] in_modifiers,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_event_source,
  output logic [6:0] out_event_code,
  output logic       out_pressed,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  hkrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  hkrt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_kind          (in_kind),
    .in_raw_code      (in_raw_code),
    .in_key_code      (in_key_code),
    .in_modifiers     (in_modifiers),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_source (out_event_source),
    .out_event_code   (out_event_code),
    .out_pressed      (out_pressed),
    .out_last         (out_last)
  );

endmodule

### hw/rtl/hkrt_chk.sv
// ----------------------------------------------------------------------------
// hkrt_chk
// port level checks for the held key release timeout tracker
// ----------------------------------------------------------------------------
module hkrt_chk import hkrt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_kind,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_event_source,
  input logic [6:0] out_event_code,
  input logic       out_pressed,
  input logic       out_last
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_source) &&
      $stable(out_event_code) && $stable(out_pressed) && $stable(out_last))
    else $error("stalled output word changed");

  // a frame tick always walks the table, so the input is held off next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_TICK) |=> in_stall)
    else $error("input taken right after a frame tick");

  // right control never shows up and modifier indexes stay in range
  a_mod_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_source == SRC_MOD) |->
      (out_event_code != {4'd0, RCTRL_BIT}) && (out_event_code[6:3] == 4'd0))
    else $error("bad modifier event code");

  // key events only ever carry held, mapped codes
  a_key_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_source == SRC_KEY) |-> out_event_code != 7'd0)
    else $error("key event with unmapped code");

endmodule

bind held_key_release_timeout_tracker_top hkrt_chk u_hkrt_chk (.*);

### test/held_key_release_timeout_tracker_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// held_key_release_timeout_tracker_event_checker
// watches the key, event and config channels of the tracker, keeps its own
// copy of the held key slots, modifier state and delay registers, works out
// the event words that each accepted key report or frame tick must give and
// compares every delivered event word field by field in order
// ----------------------------------------------------------------------------
module held_key_release_timeout_tracker_event_checker import hkrt_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_raw_code,
  input  logic [6:0] in_key_code,
  input  logic [7:0] in_modifiers,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_event_source,
  input  logic [6:0] out_event_code,
  input  logic       out_pressed,
  input  logic       out_last,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         pending,
  output int         items_seen,
  output int         ticks_seen,
  output int         words_seen,
  output int         releases_seen
);

  typedef struct packed {
    logic       src;
    logic [6:0] code;
    logic       pressed;
    logic       last;
  } key_event_word_t;

  key_event_word_t expected_events[$];

  logic       held_used  [SLOTS];
  logic [6:0] held_key   [SLOTS];
  logic [7:0] held_count [SLOTS];
  logic [7:0] mod_state;
  logic [7:0] first_delay_q;
  logic [7:0] next_delay_q;
  logic [7:0] max_raw_q;

  int err_count;
  int item_count;
  int tick_count;
  int word_count;
  int release_count;

  task automatic push_event(input logic src, input logic [6:0] code, input logic pressed);
    key_event_word_t w;
    w.src     = src;
    w.code    = code;
    w.pressed = pressed;
    w.last    = 1'b0;
    expected_events.push_back(w);
  endtask

  task automatic predict_events(input logic kind, input logic [7:0] raw,
                                input logic [6:0] key, input logic [7:0] mods);
    int added;
    int slot;
    logic [7:0] delay;
    logic [7:0] diff;
    key_event_word_t w;
    added = 0;
    if (kind == KIND_TICK) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (held_used[i]) begin
          if (held_count[i] == 8'd0) begin
            if (added < int'(MAX_RESULTS)) begin
              push_event(SRC_KEY, held_key[i], 1'b0);
              added++;
              held_used[i] = 1'b0;
            end
          end else begin
            held_count[i] = held_count[i] - 8'd1;
          end
        end
      end
    end else if (raw <= max_raw_q) begin
      diff = mods ^ mod_state;
      for (int b = 0; b < 8; b++) begin
        if (b != int'(RCTRL_BIT) && diff[b]) begin
          push_event(SRC_MOD, 7'(b), mods[b]);
          added++;
        end
      end
      mod_state = mods;
      if (key != 7'd0) begin
        slot  = -1;
        delay = 8'd0;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && held_used[i] && held_key[i] == key) begin
            slot  = i;
            delay = next_delay_q;
          end
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && !held_used[i]) begin
            slot  = i;
            delay = first_delay_q;
          end
        end
        if (slot >= 0 && added < int'(MAX_RESULTS)) begin
          held_used[slot]  = 1'b1;
          held_key[slot]   = key;
          held_count[slot] = delay;
          push_event(SRC_KEY, key, 1'b1);
          added++;
        end
      end
    end
    if (added > 0) begin
      w = expected_events.pop_back();
      w.last = 1'b1;
      expected_events.push_back(w);
    end
  endtask

  task automatic check_event_word();
    key_event_word_t w;
    if (expected_events.size() == 0) begin
      err_count++;
      $error("event word with nothing expected: source %0d code %0d pressed %0d last %0d",
             out_event_source, out_event_code, out_pressed, out_last);
    end else begin
      w = expected_events.pop_front();
      word_count++;
      if (w.src == SRC_KEY && !w.pressed) release_count++;
      if (out_event_source !== w.src) begin
        err_count++;
        $error("event_source: expected %0d, got %0d", w.src, out_event_source);
      end
      if (out_event_code !== w.code) begin
        err_count++;
        $error("event_code: expected %0d, got %0d", w.code, out_event_code);
      end
      if (out_pressed !== w.pressed) begin
        err_count++;
        $error("pressed: expected %0d, got %0d", w.pressed, out_pressed);
      end
      if (out_last !== w.last) begin
        err_count++;
        $error("last: expected %0d, got %0d", w.last, out_last);
      end
    end
  endtask

  initial begin
    err_count     = 0;
    item_count    = 0;
    tick_count    = 0;
    word_count    = 0;
    release_count = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        held_used[i]  = 1'b0;
        held_key[i]   = 7'd0;
        held_count[i] = 8'd0;
      end
      mod_state     = 8'd0;
      first_delay_q = FIRST_DELAY_RST;
      next_delay_q  = NEXT_DELAY_RST;
      max_raw_q     = MAX_RAW_CODE_RST;
      expected_events.delete();
    end else begin
      if (out_valid && !out_stall) check_event_word();
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_FIRST_DELAY:  first_delay_q = cfg_data;
          REG_NEXT_DELAY:   next_delay_q  = cfg_data;
          REG_MAX_RAW_CODE: max_raw_q     = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        item_count++;
        if (in_kind == KIND_TICK) tick_count++;
        predict_events(in_kind, in_raw_code, in_key_code, in_modifiers);
      end
    end
    mismatches    <= err_count;
    pending       <= expected_events.size();
    items_seen    <= item_count;
    ticks_seen    <= tick_count;
    words_seen    <= word_count;
    releases_seen <= release_count;
  end

endmodule

### test/held_key_release_timeout_tracker_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// held_key_release_timeout_tracker_top_test
// drives key reports and frame ticks into the tracker under random sender
// gaps and receiver stalls, steps the delay and raw code limit registers
// through several settings between phases, and reports the verdict of the
// event checker
// ----------------------------------------------------------------------------
module held_key_release_timeout_tracker_top_test;
  import hkrt_pkg::*;

  localparam int   SLOTS          = 8;
  localparam int   DRAIN_CYCLES   = 3 * (SLOTS + 3);
  localparam int   HOLD_CYCLES    = 150;
  localparam int   WATCHDOG_LIMIT = 2000;
  localparam logic KIND_REPORT    = ~KIND_TICK;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_kind;
  logic [7:0] in_raw_code;
  logic [6:0] in_key_code;
  logic [7:0] in_modifiers;
  logic       out_valid;
  logic       out_stall;
  logic       out_event_source;
  logic [6:0] out_event_code;
  logic       out_pressed;
  logic       out_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  int mismatches;
  int pending;
  int items_seen;
  int ticks_seen;
  int words_seen;
  int releases_seen;

  bit         idle_on  = 1'b1;
  bit         hold_req = 1'b0;
  logic [7:0] cur_max_raw;
  logic [7:0] cur_mods;
  int         stuck_cycles = 0;

  held_key_release_timeout_tracker_top #(.SLOTS(SLOTS)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_raw_code      (in_raw_code),
    .in_key_code      (in_key_code),
    .in_modifiers     (in_modifiers),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_source (out_event_source),
    .out_event_code   (out_event_code),
    .out_pressed      (out_pressed),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  held_key_release_timeout_tracker_event_checker #(.SLOTS(SLOTS)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_raw_code      (in_raw_code),
    .in_key_code      (in_key_code),
    .in_modifiers     (in_modifiers),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_source (out_event_source),
    .out_event_code   (out_event_code),
    .out_pressed      (out_pressed),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .pending          (pending),
    .items_seen       (items_seen),
    .ticks_seen       (ticks_seen),
    .words_seen       (words_seen),
    .releases_seen    (releases_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // event receiver: stall bursts, free runs and one long hold-off
  initial begin
    int run;
    bit hold_taken;
    hold_taken = 1'b0;
    out_stall <= 1'b0;
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        run = HOLD_CYCLES;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        run = $urandom_range(1, 17);
      end else begin
        out_stall <= 1'b0;
        run = $urandom_range(1, 24);
      end
      repeat (run) @(posedge clk);
    end
  end

  task automatic send_word(input logic kind, input logic [7:0] raw,
                           input logic [6:0] key, input logic [7:0] mods);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_raw_code  <= raw;
    in_key_code  <= key;
    in_modifiers <= mods;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_word();
    logic       kind;
    logic [7:0] raw;
    logic [6:0] key;
    logic [7:0] mods;
    int         pick;
    if ($urandom_range(0, 9) < 4) begin
      send_word(KIND_TICK, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                8'($urandom_range(0, 255)));
    end else begin
      kind = KIND_REPORT;
      if ($urandom_range(0, 9) == 0) raw = 8'($urandom_range(0, 255));
      else raw = 8'($urandom_range(0, cur_max_raw));
      pick = $urandom_range(0, 9);
      if (pick < 7) key = 7'($urandom_range(1, 10));
      else if (pick == 7) key = 7'd0;
      else key = 7'($urandom_range(0, 127));
      pick = $urandom_range(0, 19);
      if (pick < 12) mods = cur_mods;
      else if (pick < 17) mods = cur_mods ^ (8'd1 << $urandom_range(0, 7));
      else mods = 8'($urandom_range(0, 255));
      cur_mods = mods;
      send_word(kind, raw, key, mods);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_delays(input logic [7:0] first_frames, input logic [7:0] next_frames,
                            input logic [7:0] max_raw);
    write_reg(REG_FIRST_DELAY, first_frames);
    write_reg(REG_NEXT_DELAY, next_frames);
    write_reg(REG_MAX_RAW_CODE, max_raw);
    cfg_valid <= 1'b0;
    cur_max_raw = max_raw;
  endtask

  task automatic run_random(input int count);
    repeat (count) send_random_word();
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_kind      <= KIND_TICK;
    in_raw_code  <= 8'd0;
    in_key_code  <= 7'd0;
    in_modifiers <= 8'd0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_FIRST_DELAY;
    cfg_data     <= 8'd0;
    cur_max_raw  = MAX_RAW_CODE_RST;
    cur_mods     = 8'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at reset register values
    send_word(KIND_TICK,   8'd0,   7'd0,   8'h00);
    send_word(KIND_REPORT, 8'd0,   7'd1,   8'hFF);
    send_word(KIND_REPORT, 8'd99,  7'd1,   8'hFF);
    send_word(KIND_REPORT, 8'd100, 7'd2,   8'h00);
    send_word(KIND_REPORT, 8'd255, 7'd127, 8'h55);
    send_word(KIND_REPORT, 8'd5,   7'd0,   8'hEF);
    send_word(KIND_REPORT, 8'd5,   7'd0,   8'h00);
    send_word(KIND_REPORT, 8'd7,   7'd127, 8'h10);
    send_word(KIND_REPORT, 8'd8,   7'd2,   8'h10);
    send_word(KIND_REPORT, 8'd9,   7'd3,   8'h00);
    send_word(KIND_REPORT, 8'd10,  7'd4,   8'h01);
    send_word(KIND_REPORT, 8'd11,  7'd5,   8'h80);
    send_word(KIND_REPORT, 8'd12,  7'd6,   8'h80);
    send_word(KIND_REPORT, 8'd13,  7'd7,   8'h80);
    send_word(KIND_REPORT, 8'd14,  7'd8,   8'h80);
    send_word(KIND_REPORT, 8'd15,  7'd127, 8'h80);
    send_word(KIND_TICK,   8'hFF,  7'h7F,  8'hFF);
    send_word(KIND_REPORT, 8'd16,  7'd64,  8'h00);
    cur_mods = 8'h00;

    run_random(90);
    hold_req = 1'b1;
    run_random(30);
    wait_idle();

    set_delays(8'd0, 8'd0, 8'd255);
    run_random(70);
    wait_idle();

    set_delays(8'd255, 8'd255, 8'd0);
    run_random(50);
    wait_idle();

    set_delays(8'd3, 8'd1, 8'd127);
    run_random(100);
    wait_idle();

    set_delays(8'($urandom_range(1, 12)), 8'($urandom_range(0, 6)), 8'd200);
    idle_on = 1'b0;
    run_random(80);
    wait_idle();

    $display("run covered %0d input words (%0d frame ticks) over five register settings",
             items_seen, ticks_seen);
    $display("%0d event words checked, %0d of them timed-out key releases",
             words_seen, releases_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
